### rtl/hol_pkg.sv
// Shared constants, types and the hex digit decoder of the object line loader.
package hol_pkg;

  // Sizes of the memory and the column layout
  localparam int unsigned MEM_SIZE   = 4096;
  localparam int unsigned BAR_COLUMN = 28;
  localparam int unsigned LINE_LEN   = BAR_COLUMN + 1;
  localparam int unsigned ADDR_FIRST = 2;
  localparam int unsigned DATA_FIRST = 7;
  localparam int unsigned DATA_SLOTS = BAR_COLUMN - DATA_FIRST;
  localparam int unsigned MAX_BYTES  = DATA_SLOTS / 2;

  // Field and counter widths
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned COL_W  = $clog2(LINE_LEN + 1);
  localparam int unsigned DCNT_W = $clog2(DATA_SLOTS + 1);
  localparam int unsigned NB_W   = $clog2(MAX_BYTES + 1);
  localparam int unsigned DATA_W = MAX_BYTES * BYTE_W;

  // Characters of the layout
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_DIG_LO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_HI = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPR_LO = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPR_HI = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LWR_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LWR_HI = 8'h66;

  // What a finished line asks the back end to do
  typedef enum logic [1:0] {
    KIND_NOWRITE,
    KIND_WRITE,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [NB_W-1:0]   nbytes;
    logic [DATA_W-1:0] data;    // byte i in data[8i+7:8i]
  } line_desc_t;

  // Returns {is_hex, nibble}
  function automatic logic [NIB_W:0] hex_decode(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    logic              ok;
    t  = '0;
    ok = 1'b0;
    if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
      t  = c - CH_DIG_LO;
      ok = 1'b1;
    end else if (c >= CH_UPR_LO && c <= CH_UPR_HI) begin
      t  = c - CH_UPR_LO + 8'd10;
      ok = 1'b1;
    end else if (c >= CH_LWR_LO && c <= CH_LWR_HI) begin
      t  = c - CH_LWR_LO + 8'd10;
      ok = 1'b1;
    end
    return {ok, t[NIB_W-1:0]};
  endfunction

endpackage

### rtl/hol_front.sv
// Front end: takes characters, checks the column layout as they arrive, classifies each line.
module hol_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 char_code_i,
  input  logic                       end_of_line_i,
  output logic                       push_o,
  output hol_pkg::line_desc_t        push_desc_o,
  input  logic                       full_i
);
  import hol_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic              nonblank_q, nonblank_d;
  logic              fmt_bad_q, fmt_bad_d;
  logic              bar_ok_q, bar_ok_d;
  logic              seen_space_q, seen_space_d;
  logic [DCNT_W-1:0] dcount_q, dcount_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [ADDR_W-1:0] last_addr_q, last_addr_d;
  logic              failed_q, failed_d;

  logic              accept;
  logic              is_char;
  logic              is_eol;
  logic [NIB_W:0]    hex;
  logic              is_space;
  logic              in_data;
  logic [NB_W-1:0]   nbytes;
  logic [ADDR_W:0]   end_addr;
  logic              fits;
  logic              bad_line;
  logic              blank;

  // A line end waits for room in the queue; characters never wait
  assign in_ready_o = !end_of_line_i || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_char    = accept && !end_of_line_i && (col_q < COL_W'(LINE_LEN));
  assign is_eol     = accept && end_of_line_i;
  assign hex        = hex_decode(char_code_i);
  assign is_space   = (char_code_i == CH_SPACE);
  assign in_data    = (col_q >= COL_W'(DATA_FIRST)) && (col_q < COL_W'(BAR_COLUMN));

  // Line classification from the flags gathered so far
  assign nbytes   = NB_W'(dcount_q >> 1);
  assign end_addr = {1'b0, addr_q} + (ADDR_W+1)'(nbytes);
  assign fits     = (end_addr <= (ADDR_W+1)'(MEM_SIZE));
  assign blank    = !nonblank_q;
  assign bad_line = (col_q < COL_W'(LINE_LEN)) || !bar_ok_q ||
                    (!blank && (fmt_bad_q || dcount_q[0] || !fits || addr_q < last_addr_q));

  always_comb begin
    push_o             = is_eol && !failed_q;
    push_desc_o.addr   = addr_q;
    push_desc_o.nbytes = nbytes;
    push_desc_o.data   = data_q;
    if (bad_line) begin
      push_desc_o.kind = KIND_ERROR;
    end else if (blank || nbytes == '0) begin
      push_desc_o.kind = KIND_NOWRITE;
    end else begin
      push_desc_o.kind = KIND_WRITE;
    end
  end

  // Per-column checks and capture
  always_comb begin
    col_d        = col_q;
    nonblank_d   = nonblank_q;
    fmt_bad_d    = fmt_bad_q;
    bar_ok_d     = bar_ok_q;
    seen_space_d = seen_space_q;
    dcount_d     = dcount_q;
    addr_d       = addr_q;
    data_d       = data_q;
    last_addr_d  = last_addr_q;
    failed_d     = failed_q;

    if (is_char) begin
      col_d = col_q + 1'b1;
      if (col_q < COL_W'(BAR_COLUMN) && !is_space) begin
        nonblank_d = 1'b1;
      end
      if (col_q == COL_W'(BAR_COLUMN) && char_code_i == CH_BAR) begin
        bar_ok_d = 1'b1;
      end
      if ((col_q == COL_W'(0) && char_code_i != CH_ZERO) ||
          (col_q == COL_W'(1) && char_code_i != CH_X) ||
          (col_q == COL_W'(5) && char_code_i != CH_COLON) ||
          (col_q == COL_W'(6) && !is_space)) begin
        fmt_bad_d = 1'b1;
      end
      // Address digits
      if (col_q >= COL_W'(ADDR_FIRST) && col_q < COL_W'(ADDR_FIRST + 3)) begin
        if (!hex[NIB_W]) begin
          fmt_bad_d = 1'b1;
        end
        addr_d = {addr_q[ADDR_W-NIB_W-1:0], hex[NIB_W-1:0]};
      end
      // Data digits, then spaces only
      if (in_data) begin
        if (is_space) begin
          seen_space_d = 1'b1;
        end else if (seen_space_q || !hex[NIB_W]) begin
          fmt_bad_d = 1'b1;
        end else begin
          dcount_d = dcount_q + 1'b1;
        end
      end
      for (int j = 0; j < 2 * MAX_BYTES; j++) begin
        if (col_q == COL_W'(DATA_FIRST + j)) begin
          data_d[(j / 2) * BYTE_W + ((j % 2 == 0) ? NIB_W : 0) +: NIB_W] = hex[NIB_W-1:0];
        end
      end
    end

    if (is_eol) begin
      col_d        = '0;
      nonblank_d   = 1'b0;
      fmt_bad_d    = 1'b0;
      bar_ok_d     = 1'b0;
      seen_space_d = 1'b0;
      dcount_d     = '0;
      if (!failed_q) begin
        if (push_desc_o.kind == KIND_ERROR) begin
          failed_d = 1'b1;
        end else if (push_desc_o.kind == KIND_WRITE) begin
          last_addr_d = end_addr[ADDR_W-1:0] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      nonblank_q   <= 1'b0;
      fmt_bad_q    <= 1'b0;
      bar_ok_q     <= 1'b0;
      seen_space_q <= 1'b0;
      dcount_q     <= '0;
      last_addr_q  <= '0;
      failed_q     <= 1'b0;
    end else begin
      col_q        <= col_d;
      nonblank_q   <= nonblank_d;
      fmt_bad_q    <= fmt_bad_d;
      bar_ok_q     <= bar_ok_d;
      seen_space_q <= seen_space_d;
      dcount_q     <= dcount_d;
      last_addr_q  <= last_addr_d;
      failed_q     <= failed_d;
    end
  end

  // Payload capture, no reset
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    data_q <= data_d;
  end

endmodule

### rtl/hol_fifo.sv
// Two-entry queue of classified lines between front and back end.
module hol_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hol_pkg::line_desc_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hol_pkg::line_desc_t pop_data_o
);
  import hol_pkg::*;

  line_desc_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/hol_back.sv
// Back end: turns each queued line into its result words, one per cycle unless out_ready_i stalls the output.
module hol_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_valid_i,
  input  hol_pkg::line_desc_t desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                write_valid_o,
  output logic [11:0]         write_addr_o,
  output logic [7:0]          write_byte_o,
  output logic                line_error_o,
  output logic                last_o
);
  import hol_pkg::*;

  // Line in progress
  logic              cur_valid_q;
  kind_e             kind_q;
  logic [ADDR_W-1:0] addr_q;
  logic [NB_W-1:0]   left_q;
  logic [DATA_W-1:0] data_q;

  // Output register
  logic              out_valid_q;
  logic              wv_q;
  logic [ADDR_W-1:0] wa_q;
  logic [BYTE_W-1:0] wb_q;
  logic              err_q;
  logic              last_q;

  logic slot_free;
  logic emit;
  logic emit_last;
  logic is_write;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = cur_valid_q && slot_free;
  assign is_write  = (kind_q == KIND_WRITE);
  assign emit_last = !is_write || (left_q == NB_W'(1));
  assign pop_o     = fifo_valid_i && (!cur_valid_q || (emit && emit_last));

  // Line sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
    end else if (emit && emit_last) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= desc_i.kind;
      addr_q <= desc_i.addr;
      left_q <= desc_i.nbytes;
      data_q <= desc_i.data;
    end else if (emit) begin
      addr_q <= addr_q + 1'b1;
      left_q <= left_q - 1'b1;
      data_q <= data_q >> BYTE_W;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      wv_q   <= is_write;
      wa_q   <= is_write ? addr_q : '0;
      wb_q   <= is_write ? data_q[BYTE_W-1:0] : '0;
      err_q  <= (kind_q == KIND_ERROR);
      last_q <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign write_valid_o = wv_q;
  assign write_addr_o  = wa_q;
  assign write_byte_o  = wb_q;
  assign line_error_o  = err_q;
  assign last_o        = last_q;

endmodule

### rtl/hex_object_line_loader.sv
// Top level of the object text line loader: front end, line queue, back end.
//
//   channel | handshake              | word
//   --------+------------------------+-------------------------------------------------
//   in      | in_valid_i / in_ready_o   | char_code_i, end_of_line_i
//   out     | out_valid_o / out_ready_i | write_valid_o, write_addr_o, write_byte_o,
//           |                           | line_error_o, last_o
//
// One character word is taken every cycle. A line end is taken as soon as the
// two-line queue has room; it stalls only while both entries are held.
// While out_ready_i does not stall it, the back end gives one result word per cycle:
// up to MAX_BYTES writes per line, or a single no-write or error word. An output register
// parts the two sides. Reset clears all control state at once; no clearing pass is needed.
// After the error word of the first bad line, words are taken but no results given.
module hex_object_line_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [11:0] write_addr_o,
  output logic [7:0]  write_byte_o,
  output logic        line_error_o,
  output logic        last_o
);
  import hol_pkg::*;

  logic       push;
  line_desc_t push_desc;
  logic       full;
  logic       pop;
  logic       fifo_valid;
  line_desc_t pop_desc;

  hol_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_line_i (end_of_line_i),
    .push_o        (push),
    .push_desc_o   (push_desc),
    .full_i        (full)
  );

  hol_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_desc)
  );

  hol_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_valid_i  (fifo_valid),
    .desc_i        (pop_desc),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_valid_o (write_valid_o),
    .write_addr_o  (write_addr_o),
    .write_byte_o  (write_byte_o),
    .line_error_o  (line_error_o),
    .last_o        (last_o)
  );

endmodule

### rtl/hol_checker.sv
// Port-level checks of the loader, bound to the top level.
module hol_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        end_of_line_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_valid_o,
  input logic [11:0] write_addr_o,
  input logic [7:0]  write_byte_o,
  input logic        line_error_o,
  input logic        last_o
);

  logic out_acc;
  logic saw_err_q;

  assign out_acc = out_valid_o && out_ready_i;

  // Remember a delivered error word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_err_q <= 1'b0;
    end else if (out_acc && line_error_o) begin
      saw_err_q <= 1'b1;
    end
  end

  // Character words are never stalled
  a_char_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !end_of_line_i |-> in_ready_o)
    else $error("character word stalled");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_addr_o) &&
      $stable(write_byte_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // Nothing after an error until reset
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saw_err_q |-> !out_valid_o)
    else $error("result after error word");

  // Error word shape
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_error_o |-> !write_valid_o && last_o &&
      write_addr_o == 12'd0 && write_byte_o == 8'd0)
    else $error("malformed error word");

  // A no-write word closes its line
  a_nowrite_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> last_o)
    else $error("no-write word without last");

endmodule

bind hex_object_line_loader hol_checker u_hol_checker (.*);
